// File: rtl/gtpu_pkg.sv
// Package for the graphics tag packet unpacker.
// Holds the phase and event codes and the result and push types.
// No dependencies.
`default_nettype none

package gtpu_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned LoopW   = 15;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned QDepth  = 3;
  localparam int unsigned QCntW   = 2;

  typedef enum logic [3:0] {
    PH_TAG0 = 4'b0001,
    PH_LIST = 4'b0010,
    PH_DATA = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    EV_WRITE = 2'd0,
    EV_DONE  = 2'd1,
    EV_TRUNC = 2'd2,
    EV_UNSUP = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    MODE_PACKED = 2'd0,
    MODE_REGLIST = 2'd1,
    MODE_IMAGE  = 2'd2,
    MODE_DISABLED = 2'd3
  } mode_e;

  typedef struct packed {
    event_e           ev;
    logic [IdxW-1:0]  idx;
    logic [WordW-1:0] data;
    logic             eop;
    logic             last;
  } result_t;

  typedef struct packed {
    logic       push;
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/gtpu_unpack.sv
// Input register, packet state and per-word decode of the unpacker.
// Depends on gtpu_pkg.
`default_nettype none

module gtpu_unpack (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [gtpu_pkg::WordW-1:0]  word_i,
  input  wire logic                        word_last_i,
  input  wire logic                        space_ok_i,
  output gtpu_pkg::push_t                  push_o
);

  logic                       in_valid_q, in_valid_d;
  logic [gtpu_pkg::WordW-1:0] word_q;
  logic                       last_q;

  gtpu_pkg::phase_e           phase_q, phase_d;
  logic [gtpu_pkg::LoopW-1:0] loops_q, loops_d;
  logic [gtpu_pkg::IdxW-1:0]  pos_q, pos_d;
  logic [gtpu_pkg::IdxW-1:0]  cnt_q, cnt_d;
  logic [gtpu_pkg::WordW-1:0] list_q, list_d;
  logic                       eop_q, eop_d;

  logic                       take;
  logic                       in_acc;
  logic [gtpu_pkg::IdxW-1:0]  endpos;
  logic [gtpu_pkg::IdxW-1:0]  idx;
  logic [gtpu_pkg::LoopW-1:0] loops_dec;
  gtpu_pkg::result_t          r0, r1;
  logic [1:0]                 num;

  assign take       = in_valid_q & space_ok_i;
  assign in_ready_o = ~in_valid_q | take;
  assign in_acc     = in_valid_i & in_ready_o;
  assign in_valid_d = in_acc | (in_valid_q & ~take);

  assign endpos    = cnt_q - gtpu_pkg::IdxW'(1);
  assign idx       = list_q[{pos_q, 2'b00} +: gtpu_pkg::IdxW];
  assign loops_dec = (pos_q == endpos) ? loops_q - gtpu_pkg::LoopW'(1) : loops_q;

  always_comb begin
    phase_d = phase_q;
    loops_d = loops_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    list_d  = list_q;
    eop_d   = eop_q;
    r0      = '0;
    r1      = '0;
    num     = 2'd0;
    unique case (phase_q)
      gtpu_pkg::PH_TAG0: begin
        loops_d = word_q[gtpu_pkg::LoopW-1:0];
        eop_d   = word_q[15];
        cnt_d   = word_q[63:60];
        pos_d   = '0;
        if (gtpu_pkg::mode_e'(word_q[59:58]) != gtpu_pkg::MODE_PACKED) begin
          r0.ev   = gtpu_pkg::EV_UNSUP;
          r0.eop  = word_q[15];
          r0.last = 1'b1;
          num     = 2'd1;
          phase_d = last_q ? gtpu_pkg::PH_TAG0 : gtpu_pkg::PH_SKIP;
        end else if (last_q) begin
          r0.ev   = (word_q[gtpu_pkg::LoopW-1:0] == '0) ? gtpu_pkg::EV_DONE
                                                         : gtpu_pkg::EV_TRUNC;
          r0.eop  = word_q[15];
          r0.last = 1'b1;
          num     = 2'd1;
          phase_d = gtpu_pkg::PH_TAG0;
        end else begin
          phase_d = gtpu_pkg::PH_LIST;
        end
      end
      gtpu_pkg::PH_LIST: begin
        list_d  = word_q;
        r0.eop  = eop_q;
        r0.last = 1'b1;
        if (loops_q == '0) begin
          r0.ev   = gtpu_pkg::EV_DONE;
          num     = 2'd1;
          phase_d = last_q ? gtpu_pkg::PH_TAG0 : gtpu_pkg::PH_SKIP;
        end else if (last_q) begin
          r0.ev   = gtpu_pkg::EV_TRUNC;
          num     = 2'd1;
          phase_d = gtpu_pkg::PH_TAG0;
        end else begin
          phase_d = gtpu_pkg::PH_DATA;
        end
      end
      gtpu_pkg::PH_DATA: begin
        pos_d   = (pos_q == endpos) ? '0 : pos_q + gtpu_pkg::IdxW'(1);
        loops_d = loops_dec;
        r0.ev   = gtpu_pkg::EV_WRITE;
        r0.idx  = idx;
        r0.data = word_q;
        r1.eop  = eop_q;
        r1.last = 1'b1;
        if (loops_dec == '0) begin
          r1.ev   = gtpu_pkg::EV_DONE;
          num     = 2'd2;
          phase_d = last_q ? gtpu_pkg::PH_TAG0 : gtpu_pkg::PH_SKIP;
        end else if (last_q) begin
          r1.ev   = gtpu_pkg::EV_TRUNC;
          num     = 2'd2;
          phase_d = gtpu_pkg::PH_TAG0;
        end else begin
          r0.last = 1'b1;
          num     = 2'd1;
        end
      end
      gtpu_pkg::PH_SKIP: begin
        if (last_q) begin
          phase_d = gtpu_pkg::PH_TAG0;
        end
      end
      default: begin
        phase_d = gtpu_pkg::PH_TAG0;
      end
    endcase
  end

  assign push_o = '{push: take, num: num, res0: r0, res1: r1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= gtpu_pkg::PH_TAG0;
      loops_q    <= '0;
      pos_q      <= '0;
      cnt_q      <= '0;
      list_q     <= '0;
      eop_q      <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (take) begin
        phase_q <= phase_d;
        loops_q <= loops_d;
        pos_q   <= pos_d;
        cnt_q   <= cnt_d;
        list_q  <= list_d;
        eop_q   <= eop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      word_q <= word_i;
      last_q <= word_last_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gtpu_res_queue.sv
// Three-entry result queue; the head entry drives the result channel.
// Takes up to two results per cycle. Depends on gtpu_pkg.
`default_nettype none

module gtpu_res_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire gtpu_pkg::push_t push_i,
  output logic                 space_ok_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output gtpu_pkg::result_t    head_o
);

  logic [gtpu_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic [gtpu_pkg::QCntW-1:0] base;
  logic [gtpu_pkg::QCntW-1:0] base1;
  logic                       pop;
  gtpu_pkg::result_t          slot_q [gtpu_pkg::QDepth];
  gtpu_pkg::result_t          slot_d [gtpu_pkg::QDepth];

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = slot_q[0];
  assign pop         = out_valid_o & out_ready_i;
  assign base        = cnt_q - gtpu_pkg::QCntW'(pop);
  assign base1       = base + gtpu_pkg::QCntW'(1);
  assign space_ok_o  = (base <= gtpu_pkg::QCntW'(gtpu_pkg::QDepth - 2));
  assign cnt_d       = base + (push_i.push ? push_i.num : '0);

  always_comb begin
    for (int i = 0; i < gtpu_pkg::QDepth; i++) begin
      slot_d[i] = slot_q[i];
    end
    if (pop) begin
      for (int i = 0; i < gtpu_pkg::QDepth - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
    end
    for (int i = 0; i < gtpu_pkg::QDepth; i++) begin
      if (push_i.push && (push_i.num != 2'd0) && (gtpu_pkg::QCntW'(i) == base)) begin
        slot_d[i] = push_i.res0;
      end else if (push_i.push && (push_i.num == 2'd2) &&
                   (gtpu_pkg::QCntW'(i) == base1)) begin
        slot_d[i] = push_i.res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < gtpu_pkg::QDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/graphics_tag_packet_unpacker.sv
// An accepted word is registered, decoded, and its results written to the queue.
// Throughput: one word per cycle while each word gives at most one result and the
// output takes each result; a word that gives two results pushes both at once.
// The rate is set by the three-entry result queue that feeds the output.
// Reset (rst_ni low, asynchronous) returns to expecting a tag word, queue empty.
`default_nettype none

module graphics_tag_packet_unpacker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [gtpu_pkg::WordW-1:0]  word_i,
  input  wire logic                        word_last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       event_res_o,
  output logic [gtpu_pkg::IdxW-1:0]        reg_index_o,
  output logic [gtpu_pkg::WordW-1:0]       reg_data_o,
  output logic                             end_of_packet_o,
  output logic                             result_last_o
);

  gtpu_pkg::push_t   push;
  gtpu_pkg::result_t head;
  logic              space_ok;

  gtpu_unpack u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .word_i      (word_i),
    .word_last_i (word_last_i),
    .space_ok_i  (space_ok),
    .push_o      (push)
  );

  gtpu_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign event_res_o     = head.ev;
  assign reg_index_o     = head.idx;
  assign reg_data_o      = head.data;
  assign end_of_packet_o = head.eop;
  assign result_last_o   = head.last;

endmodule

`default_nettype wire

// File: rtl/gtpu_checker.sv
// Port-level checker for the unpacker and its bind to the top level.
// Depends on gtpu_pkg and graphics_tag_packet_unpacker.
`default_nettype none

module gtpu_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [1:0]                  event_res_o,
  input wire logic [gtpu_pkg::IdxW-1:0]   reg_index_o,
  input wire logic [gtpu_pkg::WordW-1:0]  reg_data_o,
  input wire logic                        end_of_packet_o,
  input wire logic                        result_last_o
);

  logic is_write;
  assign is_write = (event_res_o == gtpu_pkg::EV_WRITE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_write |->
      reg_index_o == '0 && reg_data_o == '0 && result_last_o)
    else $error("status result carries write fields");

  a_write_no_eop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_write |-> !end_of_packet_o)
    else $error("write result carries end-of-packet");

  a_write_then_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && is_write && !result_last_o |=>
      out_valid_o && (event_res_o == gtpu_pkg::EV_DONE ||
                      event_res_o == gtpu_pkg::EV_TRUNC))
    else $error("write not followed by done or truncated");

endmodule

bind graphics_tag_packet_unpacker gtpu_checker u_gtpu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .event_res_o     (event_res_o),
  .reg_index_o     (reg_index_o),
  .reg_data_o      (reg_data_o),
  .end_of_packet_o (end_of_packet_o),
  .result_last_o   (result_last_o)
);

`default_nettype wire

// File: test/graphics_tag_packet_unpacker_test.sv
`timescale 1ns / 100ps
// Testbench for graphics_tag_packet_unpacker: random and directed tag packets,
// with a scoreboard class that predicts each result and checks it in order.
// Depends on gtpu_pkg and the unpacker RTL.

module graphics_tag_packet_unpacker_test;
  import gtpu_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TargetWords   = 1450;
  localparam int unsigned CalmWords     = 1250;
  localparam int unsigned DrainCycles   = 8;

  typedef enum int {FillRandom, FillZero, FillOnes} fill_e;

  class tag_unpack_model;
    phase_e           phase;
    logic [LoopW-1:0] loops_left;
    logic [3:0]       reg_pos;
    logic [3:0]       reg_count;
    logic [63:0]      reg_list;
    logic             eop;
    mode_e            mode;
    result_t          owed[$];
    int               errors;

    function new();
      phase      = PH_TAG0;
      loops_left = '0;
      reg_pos    = '0;
      reg_count  = '0;
      reg_list   = '0;
      eop        = 1'b0;
      mode       = MODE_PACKED;
      errors     = 0;
    endfunction

    function void owe(event_e ev, logic [3:0] idx, logic [63:0] data, logic e, logic l);
      result_t r;
      r.ev   = ev;
      r.idx  = idx;
      r.data = data;
      r.eop  = e;
      r.last = l;
      owed.push_back(r);
    endfunction

    function void take_word(logic [63:0] w, logic l);
      logic [3:0] idx;
      logic [3:0] end_pos;
      case (phase)
        PH_TAG0: begin
          loops_left = w[14:0];
          eop        = w[15];
          mode       = mode_e'(w[59:58]);
          reg_count  = w[63:60];
          reg_pos    = '0;
          if (mode != MODE_PACKED) begin
            owe(EV_UNSUP, '0, '0, eop, 1'b1);
            phase = l ? PH_TAG0 : PH_SKIP;
          end else if (l) begin
            owe((loops_left == 0) ? EV_DONE : EV_TRUNC, '0, '0, eop, 1'b1);
            phase = PH_TAG0;
          end else begin
            phase = PH_LIST;
          end
        end
        PH_LIST: begin
          reg_list = w;
          if (loops_left == 0) begin
            owe(EV_DONE, '0, '0, eop, 1'b1);
            phase = l ? PH_TAG0 : PH_SKIP;
          end else if (l) begin
            owe(EV_TRUNC, '0, '0, eop, 1'b1);
            phase = PH_TAG0;
          end else begin
            phase = PH_DATA;
          end
        end
        PH_DATA: begin
          idx     = reg_list[{reg_pos, 2'b00} +: 4];
          end_pos = reg_count - 4'd1;
          if (reg_pos == end_pos) begin
            reg_pos    = '0;
            loops_left = loops_left - 1'b1;
          end else begin
            reg_pos = reg_pos + 4'd1;
          end
          if (loops_left == 0) begin
            owe(EV_WRITE, idx, w, 1'b0, 1'b0);
            owe(EV_DONE, '0, '0, eop, 1'b1);
            phase = l ? PH_TAG0 : PH_SKIP;
          end else if (l) begin
            owe(EV_WRITE, idx, w, 1'b0, 1'b0);
            owe(EV_TRUNC, '0, '0, eop, 1'b1);
            phase = PH_TAG0;
          end else begin
            owe(EV_WRITE, idx, w, 1'b0, 1'b1);
          end
        end
        default: begin
          if (l) phase = PH_TAG0;
        end
      endcase
    endfunction

    function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] ev, logic [3:0] idx, logic [63:0] data,
                               logic e, logic l);
      result_t exp_r;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, expected none actual event %0d index %0d data %h",
                 $time, ev, idx, data);
        errors++;
        return;
      end
      exp_r = owed.pop_front();
      check_field("event_res", 64'(exp_r.ev), 64'(ev));
      check_field("reg_index", 64'(exp_r.idx), 64'(idx));
      check_field("reg_data", exp_r.data, data);
      check_field("end_of_packet", 64'(exp_r.eop), 64'(e));
      check_field("result_last", 64'(exp_r.last), 64'(l));
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [WordW-1:0]  word_i      = '0;
  logic              word_last_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        event_res_o;
  logic [IdxW-1:0]   reg_index_o;
  logic [WordW-1:0]  reg_data_o;
  logic              end_of_packet_o;
  logic              result_last_o;

  tag_unpack_model   model;
  int unsigned       words_sent = 0;
  bit                quiet = 1'b0;

  graphics_tag_packet_unpacker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .word_i          (word_i),
    .word_last_i     (word_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_res_o     (event_res_o),
    .reg_index_o     (reg_index_o),
    .reg_data_o      (reg_data_o),
    .end_of_packet_o (end_of_packet_o),
    .result_last_o   (result_last_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic send_word(input logic [63:0] w, input logic l);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    word_i      <= w;
    word_last_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (model.phase != PH_SKIP) words_sent++;
    model.take_word(w, l);
  endtask

  task automatic send_packet(input logic [14:0] nloop, input logic eop, input mode_e mode,
                             input logic [3:0] nreg, input logic [63:0] list,
                             input int total, input fill_e fill);
    logic [63:0] tag;
    logic [63:0] w;
    int          k;
    tag        = {$urandom, $urandom};
    tag[14:0]  = nloop;
    tag[15]    = eop;
    tag[59:58] = mode;
    tag[63:60] = nreg;
    send_word(tag, total == 1);
    if (total > 1) send_word(list, total == 2);
    for (k = 2; k < total; k++) begin
      case (fill)
        FillZero: w = '0;
        FillOnes: w = '1;
        default:  w = {$urandom, $urandom};
      endcase
      send_word(w, k == total - 1);
    end
  endtask

  task automatic random_packet();
    int          kind;
    int          regs;
    int          total;
    logic [14:0] nloop;
    logic [3:0]  nreg;
    mode_e       mode;
    quiet = (words_sent >= CalmWords) || ($urandom_range(0, 9) == 0);
    kind  = $urandom_range(0, 99);
    nreg  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
    regs  = (nreg == 0) ? 16 : int'(nreg);
    mode  = MODE_PACKED;
    if (kind < 65) begin
      nloop = 15'($urandom_range(1, 3));
      total = 2 + int'(nloop) * regs;
      if ($urandom_range(0, 3) == 0) total += $urandom_range(1, 3);
    end else if (kind < 80) begin
      nloop = $urandom_range(0, 1) ? 15'($urandom) : 15'($urandom_range(1, 4));
      if (nloop == 0) nloop = 15'd1;
      total = $urandom_range(1, 12);
    end else if (kind < 90) begin
      mode  = mode_e'($urandom_range(1, 3));
      nloop = 15'($urandom);
      total = $urandom_range(1, 4);
    end else begin
      nloop = '0;
      total = $urandom_range(1, 3);
    end
    send_packet(nloop, 1'($urandom_range(0, 1)), mode, nreg, {$urandom, $urandom}, total,
                FillRandom);
  endtask

  initial begin
    model = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_packet(15'd0, 1'b1, MODE_PACKED, 4'd1, '1, 1, FillRandom);
    send_packet(15'h7FFF, 1'b0, MODE_PACKED, 4'd15, '0, 1, FillRandom);
    send_packet(15'd0, 1'b0, MODE_PACKED, 4'd0, '1, 2, FillRandom);
    send_packet(15'd0, 1'b1, MODE_PACKED, 4'd3, {$urandom, $urandom}, 4, FillRandom);
    send_packet(15'd2, 1'b1, MODE_REGLIST, 4'd2, {$urandom, $urandom}, 1, FillRandom);
    send_packet(15'd1, 1'b0, MODE_DISABLED, 4'd0, {$urandom, $urandom}, 3, FillRandom);
    send_packet(15'd1, 1'b1, MODE_IMAGE, 4'd5, {$urandom, $urandom}, 2, FillRandom);
    send_packet(15'd1, 1'b1, MODE_PACKED, 4'd1, 64'hF, 3, FillOnes);
    send_packet(15'd2, 1'b0, MODE_PACKED, 4'd2, 64'hFEDC_BA98_7654_3210, 5, FillZero);
    send_packet(15'd1, 1'b1, MODE_PACKED, 4'd0, {$urandom, $urandom}, 2, FillRandom);
    send_packet(15'h7FFF, 1'b1, MODE_PACKED, 4'd15, {$urandom, $urandom}, 3, FillOnes);

    while (words_sent < TargetWords) random_packet();
    in_valid_i <= 1'b0;

    while (model.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (model.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        out_ready_i <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 6);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      model.check_result(event_res_o, reg_index_o, reg_data_o, end_of_packet_o,
                         result_last_o);
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule

// File: graphics_tag_packet_unpacker.f
rtl/gtpu_pkg.sv
rtl/gtpu_unpack.sv
rtl/gtpu_res_queue.sv
rtl/graphics_tag_packet_unpacker.sv
rtl/gtpu_checker.sv
test/graphics_tag_packet_unpacker_test.sv
